[hw/rtl/msd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse symbol decoder package
// Shared constants, configuration indexes and the Morse code tables.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int unsigned MAX_CODE_SYMBOLS_DEF = 7;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_SPACE = 1'b1;

  localparam logic [BYTE_W-1:0] SEPARATOR_RESET  = 8'd32;
  localparam logic [BYTE_W-1:0] WORD_SPACE_RESET = 8'd47;

  localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;
  localparam logic [BYTE_W-1:0] DASH_BYTE = 8'h2D;

  localparam logic [CHAR_W-1:0] SPACE_CHAR  = 7'd32;
  localparam logic [CHAR_W-1:0] NO_CHAR     = 7'd0;
  localparam logic [CHAR_W-1:0] LETTER_BASE = 7'd97;
  localparam logic [CHAR_W-1:0] DIGIT_BASE  = 7'd48;
  localparam logic [3:0]        DIGIT_LEN   = 4'd5;

  // Width of the code word handed to the matcher (first symbol is the MSB,
  // dash = 1, dot = 0, right aligned).
  localparam int unsigned CODE_W = 8;

  localparam int unsigned N_LETTERS = 26;
  localparam int unsigned N_DIGITS  = 10;
  localparam int unsigned N_MARKS   = 17;

  typedef logic [3:0]        code_len_t;
  typedef logic [CODE_W-1:0] code_bits_t;
  typedef logic [CHAR_W-1:0] char_t;

  localparam code_len_t LETTER_LEN [N_LETTERS] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2,
    4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4
  };

  localparam code_bits_t LETTER_BITS [N_LETTERS] = '{
    8'b00000001, 8'b00001000, 8'b00001010, 8'b00000100, 8'b00000000, // a..e
    8'b00000010, 8'b00000110, 8'b00000000, 8'b00000000, 8'b00000111, // f..j
    8'b00000101, 8'b00000100, 8'b00000011, 8'b00000010, 8'b00000111, // k..o
    8'b00000110, 8'b00001101, 8'b00000010, 8'b00000000, 8'b00000001, // p..t
    8'b00000001, 8'b00000001, 8'b00000011, 8'b00001001, 8'b00001011, // u..y
    8'b00001100                                                      // z
  };

  localparam code_bits_t DIGIT_BITS [N_DIGITS] = '{
    8'b00011111, 8'b00001111, 8'b00000111, 8'b00000011, 8'b00000001,
    8'b00000000, 8'b00010000, 8'b00011000, 8'b00011100, 8'b00011110
  };

  localparam code_len_t PUNCT_LEN [N_MARKS] = '{
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6
  };

  localparam code_bits_t MARK_BITS [N_MARKS] = '{
    8'b00010101, // .
    8'b00111000, // :
    8'b00110011, // ,
    8'b00101010, // ;
    8'b00001100, // ?
    8'b00010001, // =
    8'b00011110, // '
    8'b00010010, // /
    8'b00101011, // !
    8'b00100001, // -
    8'b00001101, // _
    8'b00010010, // "
    8'b00010110, // (
    8'b00101101, // )
    8'b00001001, // $
    8'b00001000, // &
    8'b00011010  // @
  };

  localparam char_t MARK_CHAR [N_MARKS] = '{
    7'd46, 7'd58, 7'd44, 7'd59, 7'd63, 7'd61, 7'd39, 7'd47, 7'd33,
    7'd45, 7'd95, 7'd34, 7'd40, 7'd41, 7'd36, 7'd38, 7'd64
  };

  // Look up a clean dot/dash code of exact length; NO_CHAR when nothing hits.
  function automatic char_t match_code(input code_bits_t bits, input code_len_t len);
    char_t res;
    logic  found;
    res   = NO_CHAR;
    found = 1'b0;
    for (int i = 0; i < N_LETTERS; i++) begin
      if (!found && len == LETTER_LEN[i] && bits == LETTER_BITS[i]) begin
        res   = LETTER_BASE + CHAR_W'(i);
        found = 1'b1;
      end
    end
    for (int i = 0; i < N_DIGITS; i++) begin
      if (!found && len == DIGIT_LEN && bits == DIGIT_BITS[i]) begin
        res   = DIGIT_BASE + CHAR_W'(i);
        found = 1'b1;
      end
    end
    for (int i = 0; i < N_MARKS; i++) begin
      if (!found && len == PUNCT_LEN[i] && bits == MARK_BITS[i]) begin
        res   = MARK_CHAR[i];
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage : msd_pkg
`default_nettype wire

[hw/rtl/msd_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse symbol decoder channels
// Valid/ready request channels for input bytes and decoded characters.
// ----------------------------------------------------------------------------
interface msd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol_byte;

  modport source (output valid, output symbol_byte, input ready);
  modport sink   (input valid, input symbol_byte, output ready);
endinterface : msd_in_if

interface msd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       undecodable;

  modport source (output valid, output character, output undecodable, input ready);
  modport sink   (input valid, input character, input undecodable, output ready);
endinterface : msd_out_if
`default_nettype wire

[hw/rtl/morse_symbol_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Morse symbol decoder
// Turns a byte stream of dots, dashes, separators and word spaces into text.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one stream byte per request. Dots and dashes (and any other
//          byte) are buffered; the separator byte, unless it follows a word
//          space, closes a code and produces one decoded character, or
//          character 0 with undecodable set. The word-space byte produces a space.
//   out_if carries the decoded characters; bytes that only fill the buffer
//          produce nothing.
//   cfg_we_i/cfg_idx_i/cfg_data_i set the separator and word-space bytes;
//          write them only while the block is idle.
// A request passes through the input register, then through the table
// lookup into the result register.
// Throughput is one byte per cycle while the receiver takes results; the
// lookup compares all table entries in parallel.
// Reset clears the buffer, restores separator 32 and word space 47, and
// empties both registers. When the receiver stalls, the result register
// holds its request and the input register takes one more byte, then
// in_if.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module morse_symbol_decoder #(
  parameter int unsigned MAX_CODE_SYMBOLS = msd_pkg::MAX_CODE_SYMBOLS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [msd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [msd_pkg::BYTE_W-1:0]    cfg_data_i,
  msd_in_if.sink                             in_if,
  msd_out_if.source                          out_if
);
  import msd_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_CODE_SYMBOLS + 1);

  // Configuration registers
  logic [BYTE_W-1:0] sep_q, ws_q;

  // Input register
  logic              in_vld_q, in_vld_d;
  logic [BYTE_W-1:0] in_byte_q, in_byte_d;

  // Code buffer: first symbol is the MSB of the code in dash_q, right aligned
  logic [MAX_CODE_SYMBOLS-1:0] dash_q, dash_d;
  logic [LEN_W-1:0]            len_q, len_d;
  logic                        other_q, other_d;
  logic                        ovf_q, ovf_d;
  logic                        prev_ws_q, prev_ws_d;

  // Result register
  logic              out_vld_q, out_vld_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_undec_q, out_undec_d;

  logic  proc;
  logic  is_sep, is_ws, is_dot, is_dash;
  logic  buf_full;
  char_t match_char;

  assign is_sep   = (in_byte_q == sep_q);
  assign is_ws    = (in_byte_q == ws_q);
  assign is_dot   = (in_byte_q == DOT_BYTE);
  assign is_dash  = (in_byte_q == DASH_BYTE);
  assign buf_full = (len_q == LEN_W'(MAX_CODE_SYMBOLS));

  // Advance the held byte when the result register is free or being drained
  assign proc        = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || proc;

  assign match_char = match_code(CODE_W'(dash_q), 4'(len_q));

  always_comb begin
    in_vld_d    = in_vld_q;
    in_byte_d   = in_byte_q;
    dash_d      = dash_q;
    len_d       = len_q;
    other_d     = other_q;
    ovf_d       = ovf_q;
    prev_ws_d   = prev_ws_q;
    out_vld_d   = out_vld_q;
    out_char_d  = out_char_q;
    out_undec_d = out_undec_q;

    if (out_if.ready) begin
      out_vld_d = 1'b0;
    end

    if (proc) begin
      in_vld_d  = 1'b0;
      prev_ws_d = is_ws;
      if (!is_sep && !is_ws) begin
        if (!buf_full) begin
          dash_d  = {dash_q[MAX_CODE_SYMBOLS-2:0], is_dash};
          other_d = other_q | (!is_dot && !is_dash);
          len_d   = len_q + LEN_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end else if (is_sep && !prev_ws_q) begin
        out_vld_d   = 1'b1;
        out_char_d  = (ovf_q || other_q) ? NO_CHAR : match_char;
        out_undec_d = (ovf_q || other_q || match_char == NO_CHAR);
        dash_d      = '0;
        len_d       = '0;
        other_d     = 1'b0;
        ovf_d       = 1'b0;
      end else if (is_ws) begin
        out_vld_d   = 1'b1;
        out_char_d  = SPACE_CHAR;
        out_undec_d = 1'b0;
      end
    end

    if (in_if.valid && in_if.ready) begin
      in_vld_d  = 1'b1;
      in_byte_d = in_if.symbol_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q     <= SEPARATOR_RESET;
      ws_q      <= WORD_SPACE_RESET;
      in_vld_q  <= 1'b0;
      dash_q    <= '0;
      len_q     <= '0;
      other_q   <= 1'b0;
      ovf_q     <= 1'b0;
      prev_ws_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SEPARATOR:  sep_q <= cfg_data_i;
          CFG_WORD_SPACE: ws_q  <= cfg_data_i;
          default: ;
        endcase
      end
      in_vld_q  <= in_vld_d;
      dash_q    <= dash_d;
      len_q     <= len_d;
      other_q   <= other_d;
      ovf_q     <= ovf_d;
      prev_ws_q <= prev_ws_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q   <= in_byte_d;
    out_char_q  <= out_char_d;
    out_undec_q <= out_undec_d;
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.character   = out_char_q;
  assign out_if.undecodable = out_undec_q;

  // Assertions
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_CODE_SYMBOLS))
    else $error("code length beyond buffer depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> buf_full)
    else $error("overflow mark set with buffer not full");

  a_other_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    other_q |-> (len_q != '0))
    else $error("other-symbol mark set on empty buffer");

  a_sep_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && is_sep && !prev_ws_q) |=> (len_q == '0 && !ovf_q && out_vld_q))
    else $error("separator did not clear buffer and post a result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_if.ready) |=> !$past(proc))
    else $error("held byte processed while result stalled");

endmodule : morse_symbol_decoder
`default_nettype wire
